>>> src/acs_pkg.sv
// ----------------------------------------------------------------------------
// acs_pkg
// shared constants, register indexes and cell control type for the
// alternating column sorter
// ----------------------------------------------------------------------------
package acs_pkg;

  localparam int MAX_ROWS   = 32;
  localparam int DATA_W     = 32;
  localparam int ROW_IDX_W  = $clog2(MAX_ROWS);
  localparam int CNT_W      = $clog2(MAX_ROWS + 1);
  localparam int ROWS_W     = 6;
  localparam int COLS_W     = 10;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 10;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_ROWS_IN_USE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_COLS_IN_USE = 2'd1;

  // control shared by every cell of the chain
  typedef struct packed {
    logic insert;   // an element is inserted this cycle
    logic desc;     // current column sorts descending
    logic load;     // copy the sorted column into the output row
    logic shift;    // output row moves one place towards cell 0
  } acs_ctrl_t;

endpackage

>>> src/alternating_column_sorter.sv
// ----------------------------------------------------------------------------
// alternating_column_sorter
// column-major stream sorter, even columns descending, odd columns ascending
// ----------------------------------------------------------------------------
// latency: first result of a column is offered the cycle after the column's
//   last element transfer; results then follow one per cycle while out_stall is low
// throughput: one element per cycle, set by the insertion chain; a completing
//   element waits until the last result of the previous column leaves, at the
//   same edge at the earliest
// reset: counters cleared, rows_in_use 32, cols_in_use 1, cell data not reset
// ----------------------------------------------------------------------------
module alternating_column_sorter import acs_pkg::*; (
  input  logic                      clk,
  input  logic                      rst_n,
  // element input
  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic signed [DATA_W-1:0]  in_element_value,
  // sorted output
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic signed [DATA_W-1:0]  out_sorted_value,
  output logic                      out_column_last,
  output logic                      out_matrix_last,
  // configuration writes
  input  logic                      cfg_valid,
  output logic                      cfg_ready,
  input  logic [CFG_IDX_W-1:0]      cfg_index,
  input  logic [CFG_DATA_W-1:0]     cfg_data
);

  // configuration registers
  logic [ROWS_W-1:0]    rows_in_use_r;
  logic [COLS_W-1:0]    cols_in_use_r;

  // column and matrix position
  logic [ROW_IDX_W-1:0] row_count_r;
  logic [COLS_W-1:0]    column_index_r;

  // output row bookkeeping
  logic [CNT_W-1:0]     ocnt_r;
  logic                 mlast_r;

  logic [CNT_W:0]       rows_eff;
  logic [COLS_W:0]      cols_eff;
  logic [CNT_W:0]       count_inc;
  logic                 complete;
  logic                 last_col;
  logic                 out_xfer;
  logic                 in_xfer;
  logic                 out_free;
  acs_ctrl_t            ctrl;

  logic                     ins_w [MAX_ROWS];
  logic signed [DATA_W-1:0] val_w [MAX_ROWS];
  logic signed [DATA_W-1:0] out_w [MAX_ROWS];

  assign cfg_ready = 1'b1;

  // zero rows acts as one, anything above the chain length as the full chain
  always_comb begin
    rows_eff = (CNT_W + 1)'(rows_in_use_r);
    if (rows_eff == '0) begin
      rows_eff = (CNT_W + 1)'(1);
    end else if (rows_eff > (CNT_W + 1)'(MAX_ROWS)) begin
      rows_eff = (CNT_W + 1)'(MAX_ROWS);
    end
    cols_eff = (cols_in_use_r == '0) ? (COLS_W + 1)'(1) : (COLS_W + 1)'(cols_in_use_r);
  end

  // element count once this transfer is in, column ends when it reaches the rows
  assign count_inc = (CNT_W + 1)'(row_count_r) + (CNT_W + 1)'(1);
  assign complete  = (count_inc >= rows_eff);
  assign last_col  = ((COLS_W + 1)'(column_index_r) + (COLS_W + 1)'(1)) >= cols_eff;

  assign out_valid = (ocnt_r != '0);
  assign out_xfer  = out_valid && !out_stall;

  // output row empty after this edge, so a finished column may be copied in
  assign out_free = (ocnt_r == '0) || ((ocnt_r == CNT_W'(1)) && out_xfer);
  assign in_stall = complete && !out_free;
  assign in_xfer  = in_valid && !in_stall;

  always_comb begin
    ctrl.insert = in_xfer;
    ctrl.desc   = !column_index_r[0];
    ctrl.load   = in_xfer && complete;
    ctrl.shift  = out_xfer;
  end

  // insertion chain: every cell compares against the broadcast element and
  // either holds, takes the element or takes its left neighbour
  for (genvar i = 0; i < MAX_ROWS; i++) begin : g_cell
    logic                     occ;
    logic                     l_ins;
    logic signed [DATA_W-1:0] l_val;
    logic signed [DATA_W-1:0] r_out;

    assign occ = (CNT_W'(i) < CNT_W'(row_count_r));

    if (i == 0) begin : g_head
      assign l_ins = 1'b0;
      assign l_val = '0;
    end else begin : g_body
      assign l_ins = ins_w[i-1];
      assign l_val = val_w[i-1];
    end

    if (i == MAX_ROWS - 1) begin : g_tail
      assign r_out = '0;
    end else begin : g_inner
      assign r_out = out_w[i+1];
    end

    acs_cell u_cell (
      .clk       (clk),
      .ctrl      (ctrl),
      .occupied  (occ),
      .new_val   (in_element_value),
      .left_ins  (l_ins),
      .left_val  (l_val),
      .right_out (r_out),
      .ins       (ins_w[i]),
      .val       (val_w[i]),
      .out_val   (out_w[i])
    );
  end

  // counters and configuration
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rows_in_use_r  <= ROWS_W'(MAX_ROWS);
      cols_in_use_r  <= COLS_W'(1);
      row_count_r    <= '0;
      column_index_r <= '0;
      ocnt_r         <= '0;
      mlast_r        <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          REG_ROWS_IN_USE: rows_in_use_r <= cfg_data[ROWS_W-1:0];
          REG_COLS_IN_USE: cols_in_use_r <= cfg_data[COLS_W-1:0];
          default: ;
        endcase
      end
      if (in_xfer && complete) begin
        // column finished: hand it to the output row, advance or wrap the column index
        row_count_r    <= '0;
        ocnt_r         <= count_inc[CNT_W-1:0];
        mlast_r        <= last_col;
        column_index_r <= last_col ? '0 : column_index_r + COLS_W'(1);
      end else begin
        if (in_xfer) begin
          row_count_r <= row_count_r + ROW_IDX_W'(1);
        end
        if (out_xfer) begin
          ocnt_r <= ocnt_r - CNT_W'(1);
        end
      end
    end
  end

  assign out_sorted_value = out_w[0];
  assign out_column_last  = (ocnt_r == CNT_W'(1));
  assign out_matrix_last  = (ocnt_r == CNT_W'(1)) && mlast_r;

  // checks
  a_ocnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    ocnt_r <= CNT_W'(MAX_ROWS))
    else $error("output row count beyond chain length");

  a_column_emits: assert property (@(posedge clk) disable iff (!rst_n)
    (in_xfer && complete) |=> out_valid)
    else $error("finished column not offered");

  a_matrix_end: assert property (@(posedge clk) disable iff (!rst_n)
    out_matrix_last |-> out_column_last)
    else $error("matrix end without column end");

  a_no_load_over: assert property (@(posedge clk) disable iff (!rst_n)
    ctrl.load |-> ((ocnt_r == '0) || (ocnt_r == CNT_W'(1) && out_xfer)))
    else $error("column copied over pending results");

endmodule

>>> src/acs_cell.sv
// ----------------------------------------------------------------------------
// acs_cell
// one insertion-sort cell with its output shift stage
// ----------------------------------------------------------------------------
module acs_cell import acs_pkg::*; (
  input  logic                     clk,
  input  acs_ctrl_t                ctrl,
  input  logic                     occupied,
  input  logic signed [DATA_W-1:0] new_val,
  input  logic                     left_ins,
  input  logic signed [DATA_W-1:0] left_val,
  input  logic signed [DATA_W-1:0] right_out,
  output logic                     ins,
  output logic signed [DATA_W-1:0] val,
  output logic signed [DATA_W-1:0] out_val
);

  logic signed [DATA_W-1:0] sort_r;
  logic signed [DATA_W-1:0] sort_nxt;
  logic signed [DATA_W-1:0] out_r;

  // new element belongs in front of the value held here
  assign ins = !occupied || (ctrl.desc ? (new_val > sort_r) : (new_val < sort_r));

  always_comb begin
    sort_nxt = sort_r;
    if (ctrl.insert && ins) begin
      sort_nxt = left_ins ? left_val : new_val;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.insert) begin
      sort_r <= sort_nxt;
    end
    if (ctrl.load) begin
      out_r <= sort_nxt;
    end else if (ctrl.shift) begin
      out_r <= right_out;
    end
  end

  assign val     = sort_r;
  assign out_val = out_r;

endmodule

>>> sim/acs_checker.sv
// ----------------------------------------------------------------------------
// acs_checker
// watches every channel of the alternating column sorter, keeps its own
// copy of the column store, counters and registers, and compares each
// sorted result transfer with the oldest expected one
// ----------------------------------------------------------------------------
module acs_checker import acs_pkg::*; (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  input  logic                     in_stall,
  input  logic signed [DATA_W-1:0] in_element_value,
  input  logic                     out_valid,
  input  logic                     out_stall,
  input  logic signed [DATA_W-1:0] out_sorted_value,
  input  logic                     out_column_last,
  input  logic                     out_matrix_last,
  input  logic                     cfg_valid,
  input  logic                     cfg_ready,
  input  logic [CFG_IDX_W-1:0]     cfg_index,
  input  logic [CFG_DATA_W-1:0]    cfg_data,
  input  logic                     end_check,
  output int                       fail_count,
  output int                       sorted_pending,
  output int                       sorted_checked
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic signed [DATA_W-1:0] value;
    logic                     column_last;
    logic                     matrix_last;
  } sorted_item_t;

  sorted_item_t             sorted_due[$];
  logic [ROWS_W-1:0]        rows_reg;
  logic [COLS_W-1:0]        cols_reg;
  logic signed [DATA_W-1:0] column_buf [MAX_ROWS];
  int                       fill_count;
  logic [COLS_W-1:0]        column_idx;
  int                       faults  = 0;
  int                       checked = 0;

  task automatic note_fault(input string msg);
    faults++;
    if (faults <= 10) $display("mismatch: %s", msg);
  endtask

  // plain insertion sort, direction chosen per column
  task automatic sort_column_buf(input int n, input bit descending);
    logic signed [DATA_W-1:0] v;
    int i;
    int j;
    for (i = 1; i < n; i++) begin
      v = column_buf[i];
      j = i;
      while (j > 0 && (descending ? (column_buf[j-1] < v) : (column_buf[j-1] > v))) begin
        column_buf[j] = column_buf[j-1];
        j--;
      end
      column_buf[j] = v;
    end
  endtask

  always @(posedge clk) begin : watch
    sorted_item_t got;
    sorted_item_t want;
    int           rows_eff;
    int           cols_eff;
    int           k;
    bit           last_col;
    if (!rst_n) begin
      rows_reg   = ROWS_W'(MAX_ROWS);
      cols_reg   = COLS_W'(1);
      fill_count = 0;
      column_idx = '0;
      sorted_due.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_ROWS_IN_USE: rows_reg = cfg_data[ROWS_W-1:0];
          REG_COLS_IN_USE: cols_reg = cfg_data[COLS_W-1:0];
          default: ;
        endcase
      end
      // results first: a column completed at this edge cannot appear yet
      if (out_valid && !out_stall) begin
        got.value       = out_sorted_value;
        got.column_last = out_column_last;
        got.matrix_last = out_matrix_last;
        if (sorted_due.size() == 0) begin
          note_fault($sformatf(
            "result %0d with nothing expected: value %0d column_last %0b matrix_last %0b",
            checked, got.value, got.column_last, got.matrix_last));
        end else begin
          want = sorted_due.pop_front();
          if (got.value !== want.value || got.column_last !== want.column_last ||
              got.matrix_last !== want.matrix_last)
            note_fault($sformatf("result %0d: expected %0d/%0b/%0b, got %0d/%0b/%0b",
                                 checked, want.value, want.column_last, want.matrix_last,
                                 got.value, got.column_last, got.matrix_last));
        end
        checked++;
      end
      if (in_valid && !in_stall) begin
        rows_eff = (rows_reg == 0) ? 1 : ((rows_reg > MAX_ROWS) ? MAX_ROWS : int'(rows_reg));
        cols_eff = (cols_reg == 0) ? 1 : int'(cols_reg);
        if (fill_count < MAX_ROWS) begin
          column_buf[fill_count] = in_element_value;
          fill_count++;
        end
        if (fill_count >= rows_eff) begin
          sort_column_buf(fill_count, column_idx[0] == 1'b0);
          last_col = (int'(column_idx) + 1 >= cols_eff);
          for (k = 0; k < fill_count; k++) begin
            want.value       = column_buf[k];
            want.column_last = (k == fill_count - 1);
            want.matrix_last = (k == fill_count - 1) && last_col;
            sorted_due.push_back(want);
          end
          fill_count = 0;
          column_idx = last_col ? '0 : column_idx + COLS_W'(1);
        end
      end
      if (end_check && sorted_due.size() != 0) begin
        note_fault($sformatf("%0d results never arrived", sorted_due.size()));
      end
    end
    fail_count     <= faults;
    sorted_pending <= sorted_due.size();
    sorted_checked <= checked;
  end

endmodule

>>> sim/alternating_column_sorter_tb.sv
// ----------------------------------------------------------------------------
// alternating_column_sorter_tb
// drives element streams and register writes into the column sorter, with
// random idling on both sides, and takes the verdict from acs_checker
// ----------------------------------------------------------------------------
module alternating_column_sorter_tb import acs_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  // the two spare register indexes, written to show they change nothing
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = 2'd3;

  localparam int RANDOM_ITEMS = 450;
  localparam int DRAIN_CYCLES = 4;
  localparam int QUIET_LIMIT  = 2000;  // cycles with no transfer before giving up

  logic                     clk = 1'b0;
  logic                     rst_n = 1'b0;
  logic                     in_valid = 1'b0;
  logic                     in_stall;
  logic signed [DATA_W-1:0] in_element_value = '0;
  logic                     out_valid;
  logic                     out_stall = 1'b0;
  logic signed [DATA_W-1:0] out_sorted_value;
  logic                     out_column_last;
  logic                     out_matrix_last;
  logic                     cfg_valid = 1'b0;
  logic                     cfg_ready;
  logic [CFG_IDX_W-1:0]     cfg_index = '0;
  logic [CFG_DATA_W-1:0]    cfg_data = '0;
  logic                     end_check = 1'b0;

  int fail_count;
  int sorted_pending;
  int sorted_checked;

  // bookkeeping for the stimulus side
  bit idle_on = 1'b1;
  int elements_sent = 0;
  int reg_writes = 0;
  int quiet_cycles = 0;
  int stall_left = 0;

  always #5 clk = ~clk;

  alternating_column_sorter uut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_element_value (in_element_value),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_sorted_value (out_sorted_value),
    .out_column_last  (out_column_last),
    .out_matrix_last  (out_matrix_last),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data)
  );

  acs_checker u_checker (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_element_value (in_element_value),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_sorted_value (out_sorted_value),
    .out_column_last  (out_column_last),
    .out_matrix_last  (out_matrix_last),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .end_check        (end_check),
    .fail_count       (fail_count),
    .sorted_pending   (sorted_pending),
    .sorted_checked   (sorted_checked)
  );

  // receiver back-pressure: random bursts of stalled cycles, each always
  // followed by an open cycle
  always @(posedge clk) begin : rx_stall
    logic stall_next;
    stall_next = 1'b0;
    if (stall_left > 0) begin
      stall_next = 1'b1;
      stall_left--;
    end else if (idle_on && !out_stall && $urandom_range(0, 7) == 0) begin
      stall_next = 1'b1;
      stall_left = $urandom_range(0, 3);
    end
    out_stall <= stall_next;
  end

  // hang detection: any transfer on any channel restarts the count
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // one element transfer, with an occasional sender gap in front of it
  task automatic send_element(input logic signed [DATA_W-1:0] v);
    int gap;
    if (idle_on && $urandom_range(0, 5) == 0) begin
      gap = $urandom_range(1, 4);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid         <= 1'b1;
    in_element_value <= v;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    elements_sent++;
    // idling on early, a clean stretch in the middle, on again, none near the end
    idle_on <= (elements_sent < 260) ||
               (elements_sent >= 330 && elements_sent < 16 + RANDOM_ITEMS - 60);
  endtask

  // stop sending and wait until every expected result has come out
  task automatic drain_results();
    in_valid <= 1'b0;
    @(posedge clk);
    while (sorted_pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // register write transfer, only issued once the block has drained
  task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
                                input logic [CFG_DATA_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    reg_writes++;
  endtask

  initial begin : stimulus
    logic [ROWS_W-1:0]        rows_sel;
    logic [ROWS_W-1:0]        rows_new;
    logic [COLS_W-1:0]        cols_sel;
    logic signed [DATA_W-1:0] v;
    int                       rows_eff;
    int                       n_cols;
    int                       c;
    int                       r;

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // ---- directed part ----
    // three-row columns: descending then ascending, extremes and a tie
    write_register(REG_ROWS_IN_USE, 10'd3);
    write_register(REG_COLS_IN_USE, 10'd2);
    send_element(32'sh8000_0000);
    send_element(32'sh7fff_ffff);
    send_element(32'sh0000_0000);
    send_element(32'sd5);
    send_element(32'sh8000_0000);
    send_element(32'sd5);
    // sender holds off until every sorted value has come out
    drain_results();

    // zero rows and zero columns both behave as one
    write_register(REG_ROWS_IN_USE, 10'h3c0);
    write_register(REG_COLS_IN_USE, 10'd0);
    send_element(-32'sd1);
    send_element(32'sh7fff_ffff);
    drain_results();

    // row count lowered while a column is half collected
    write_register(REG_ROWS_IN_USE, 10'd4);
    write_register(REG_COLS_IN_USE, 10'd3);
    write_register(REG_SPARE_LO, 10'h3ff);
    write_register(REG_SPARE_HI, 10'h155);
    send_element(32'sd10);
    send_element(-32'sd10);
    send_element(32'sd7);
    drain_results();
    write_register(REG_ROWS_IN_USE, 10'h3c2);
    send_element(32'sd0);
    // second column of the matrix, ascending, not yet the end
    send_element(32'sh7fff_fffe);
    send_element(32'sh8000_0001);
    drain_results();

    // column count lowered below the current column index
    write_register(REG_COLS_IN_USE, 10'd1);
    send_element(32'sd3);
    send_element(32'sd4);
    drain_results();
    // row count now in force
    rows_sel = 6'd2;

    // ---- random part ----
    while (elements_sent < 16 + RANDOM_ITEMS) begin
      case ($urandom_range(0, 9))
        0, 1, 2, 3, 4, 5: rows_new = ROWS_W'($urandom_range(1, 8));
        6:                rows_new = ROWS_W'(MAX_ROWS);
        7:                rows_new = ROWS_W'($urandom_range(9, 31));
        8: begin
          case ($urandom_range(0, 2))
            0:       rows_new = 6'd0;
            1:       rows_new = 6'd33;
            default: rows_new = 6'd63;
          endcase
        end
        default:          rows_new = ROWS_W'($urandom_range(2, 4));
      endcase
      if ($urandom_range(0, 7) == 0) cols_sel = 10'h3ff;
      else                           cols_sel = COLS_W'($urandom_range(0, 6));

      case ($urandom_range(0, 3))
        0: begin
          write_register(REG_ROWS_IN_USE, {4'($urandom_range(0, 15)), rows_new});
          rows_sel = rows_new;
        end
        1: write_register(REG_COLS_IN_USE, cols_sel);
        default: begin
          write_register(REG_ROWS_IN_USE, {4'($urandom_range(0, 15)), rows_new});
          write_register(REG_COLS_IN_USE, cols_sel);
          rows_sel = rows_new;
        end
      endcase
      if ($urandom_range(0, 7) == 0)
        write_register($urandom_range(0, 1) ? REG_SPARE_LO : REG_SPARE_HI,
                       CFG_DATA_W'($urandom()));

      // the row count actually in force, needed to form whole columns; a
      // column write alone leaves the previous row count in place
      rows_eff = (rows_sel == 0) ? 1 : ((rows_sel > MAX_ROWS) ? MAX_ROWS : int'(rows_sel));
      n_cols   = (rows_eff >= 16) ? $urandom_range(1, 2) : $urandom_range(1, 8);

      for (c = 0; c < n_cols; c++) begin
        for (r = 0; r < rows_eff; r++) begin
          case ($urandom_range(0, 5))
            0: v = DATA_W'($urandom_range(0, 8)) - 32'sd4;   // many ties
            1: begin
              case ($urandom_range(0, 3))
                0:       v = 32'sh8000_0000;
                1:       v = 32'sh7fff_ffff;
                2:       v = -32'sd1;
                default: v = 32'sd0;
              endcase
            end
            default: v = $urandom();
          endcase
          send_element(v);
        end
      end

      // now and then leave a column half filled, so the next settings
      // land in the middle of a column
      if (rows_eff > 1 && $urandom_range(0, 3) == 0) begin
        n_cols = $urandom_range(1, rows_eff - 1);
        for (r = 0; r < n_cols; r++) send_element($urandom());
      end
      drain_results();
    end

    // ---- wind-down ----
    drain_results();
    repeat (8) @(posedge clk);
    end_check <= 1'b1;
    @(posedge clk);
    end_check <= 1'b0;
    @(posedge clk);

    $display("covered %0d element transfers, %0d sorted results and %0d register writes",
             elements_sent, sorted_checked, reg_writes);
    $display("settings ranged over empty, odd, full and oversized columns and wrapping matrices");
    if (fail_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
